// ===== hw/rtl/ece_pkg.sv =====
// shared types, constants and fixed-point helpers for the easing curve evaluator
// no dependencies; used by easing_curve_evaluator
package ece_pkg;

  // fraction bits of progress and eased value, and of the internal format
  localparam int FracBits = 16;
  localparam int QB       = 28;

  // internal signed fixed point value, 28 fraction bits
  typedef logic signed [39:0] q_t;

  localparam q_t QOne  = 40'sd268435456;
  localparam q_t QHalf = 40'sd134217728;

  // output saturation limits
  localparam q_t OutMax = 40'sd131071;
  localparam q_t OutMin = -40'sd131072;

  // curve constants
  localparam q_t KBackA = 40'sd725199859;
  localparam q_t KBackB = 40'sd456764403;
  localparam q_t K045   = 40'sd120795955;
  localparam q_t K055   = 40'sd147639501;
  localparam q_t K075   = 40'sd201326592;

  // odd sine series for the quarter wave, highest order last
  localparam q_t SinCoef [0:4] = '{
    40'sd421657428, 40'sd173399667, 40'sd21392326, 40'sd1256749, 40'sd43068
  };

  // 2^f series, ln2^i/i!
  localparam q_t ExpCoef [0:6] = '{
    40'sd186065280, 40'sd64485312, 40'sd14899271, 40'sd2581847,
    40'sd357920, 40'sd41348, 40'sd4094
  };

  // curve index, table order
  typedef enum logic [4:0] {
    CrvLinear,
    CrvSineIn, CrvSineOut, CrvSineInOut,
    CrvQuadIn, CrvQuadOut, CrvQuadInOut,
    CrvCubicIn, CrvCubicOut, CrvCubicInOut,
    CrvQuartIn, CrvQuartOut, CrvQuartInOut,
    CrvQuintIn, CrvQuintOut, CrvQuintInOut,
    CrvExpoIn, CrvExpoOut, CrvExpoInOut,
    CrvCircIn, CrvCircOut, CrvCircInOut,
    CrvBackIn, CrvBackOut, CrvBackInOut,
    CrvElasticIn, CrvElasticOut, CrvElasticInOut,
    CrvBounceIn, CrvBounceOut, CrvBounceInOut
  } curve_e;

  // one pipeline stage: item context plus the state of every unit
  typedef struct packed {
    curve_e      crv;
    q_t          t;
    logic        lo;
    // sine unit
    q_t          sz;
    logic        sneg;
    q_t          sz2;
    q_t          sp;
    q_t          sres;
    // exp2 unit and constant divider
    logic [27:0] ef;
    logic signed [7:0] en;
    q_t          ep;
    q_t          eres;
    logic [36:0] dx;
    logic [29:0] dq;
    // square root unit
    logic [56:0] rv;
    logic [57:0] rr;
    // power unit
    q_t          pb;
    q_t          pm;
    q_t          pl;
    q_t          ps;
    q_t          px;
    // final mix
    q_t          mres;
    q_t          val;
    logic [17:0] res;
  } pipe_t;

  // product of two values, rounded half away from zero
  function automatic q_t qmul(q_t a, q_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [35:0] r;
    ma = a[39] ? 32'(-a) : 32'(a);
    mb = b[39] ? 32'(-b) : 32'(b);
    p  = 64'(ma) * 64'(mb) + (64'd1 << (QB - 1));
    r  = 36'(p >> QB);
    return (a[39] ^ b[39]) ? -q_t'({4'b0, r}) : q_t'({4'b0, r});
  endfunction

  // shift right by s, rounded half away from zero
  function automatic q_t rsr(q_t x, int unsigned s);
    logic [39:0] ax;
    logic [63:0] m;
    q_t          r;
    ax = x[39] ? 40'(-x) : 40'(x);
    m  = {24'b0, ax};
    if (s == 0) begin
      r = x;
    end else begin
      m = (m + (64'd1 << (s - 1))) >> s;
      r = x[39] ? -q_t'(m[39:0]) : q_t'(m[39:0]);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/easing_curve_evaluator.sv =====
// easing curve evaluator: 20-stage pipeline with sine, exp2, sqrt and power units
// depends on ece_pkg
// throughput: one item per cycle unless stalled; the square root recurrence at two
// result bits per stage sets the depth, the other units are matched to it
// an output stall holds the whole pipeline; input is ready whenever the output
// stage is empty or being taken
// reset clears all valid bits and sets curve_select to 0 (linear)
module easing_curve_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: curve_select
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] progress
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [17:0] eased_value
);

  localparam int NumStages   = 20;
  localparam int StSetup     = 1;
  localparam int StFirstMul  = 2;
  localparam int StPowCross  = 3;
  localparam int StPowFifth  = 4;
  localparam int StSinLast   = 7;
  localparam int StExpOne    = 8;
  localparam int StExpShift  = 9;
  localparam int StDivA      = 10;
  localparam int StDivB      = 11;
  localparam int StSqrtLast  = 16;
  localparam int StMix       = 17;
  localparam int StAssemble  = 18;
  localparam int StRound     = 19;

  logic [4:0]            curve_q;
  logic [NumStages-1:0]  valid_q;
  ece_pkg::pipe_t        pipe_q [NumStages];
  ece_pkg::pipe_t        pipe_d [NumStages];
  logic                  adv;
  logic [16:0]           raw;

  // work of one stage on the item held by the stage before it
  function automatic ece_pkg::pipe_t step(int k, ece_pkg::pipe_t a);
    ece_pkg::pipe_t b;
    ece_pkg::q_t    tt;
    ece_pkg::q_t    uu;
    ece_pkg::q_t    ang;
    ece_pkg::q_t    ex;
    ece_pkg::q_t    sx;
    ece_pkg::q_t    xo;
    ece_pkg::q_t    z;
    ece_pkg::q_t    p;
    ece_pkg::q_t    y;
    ece_pkg::q_t    mx;
    ece_pkg::q_t    my;
    ece_pkg::q_t    e1;
    ece_pkg::q_t    v;
    logic [29:0]    r;
    logic [7:0]     sh;
    logic [36:0]    e1m;
    logic [57:0]    bitv;
    logic [57:0]    trial;
    logic           mid;
    int             i;
    int             j;
    b   = a;
    tt  = a.t;
    uu  = a.t - ece_pkg::QOne;
    mid = (a.t >= ece_pkg::K045) && (a.t < ece_pkg::K055);

    // setup: unit arguments
    if (k == StSetup) begin
      ang = '0;
      ex  = '0;
      sx  = '0;
      unique case (a.crv)
        ece_pkg::CrvSineIn:       ang = tt;
        ece_pkg::CrvSineOut:      ang = uu;
        ece_pkg::CrvSineInOut:    ang = 2 * tt - ece_pkg::QOne;
        ece_pkg::CrvElasticIn:    ang = 9 * tt;
        ece_pkg::CrvElasticOut:   ang = 9 * tt + ece_pkg::QOne;
        ece_pkg::CrvElasticInOut: ang = mid ? 8 * tt : 18 * tt;
        ece_pkg::CrvBounceIn:     ang = 7 * tt;
        ece_pkg::CrvBounceOut:    ang = 7 * tt + ece_pkg::QOne;
        ece_pkg::CrvBounceInOut:  ang = 14 * tt;
        default:                  ang = '0;
      endcase
      unique case (a.crv)
        ece_pkg::CrvExpoIn:      ex = 8 * tt;
        ece_pkg::CrvExpoOut:     ex = -8 * tt;
        ece_pkg::CrvExpoInOut:   ex = a.lo ? 16 * tt : -16 * (tt - ece_pkg::QHalf);
        ece_pkg::CrvBounceIn:    ex = 6 * uu;
        ece_pkg::CrvBounceOut:   ex = -6 * tt;
        ece_pkg::CrvBounceInOut: ex = a.lo ? 8 * uu : -8 * tt;
        default:                 ex = '0;
      endcase
      unique case (a.crv)
        ece_pkg::CrvCircIn:    sx = ece_pkg::QOne - tt;
        ece_pkg::CrvCircOut:   sx = tt;
        ece_pkg::CrvCircInOut: sx = a.lo ? ece_pkg::QOne - 2 * tt : 2 * tt - ece_pkg::QOne;
        default:               sx = '0;
      endcase
      // sine: reduce to a full turn, fold to the first quadrant
      r      = ang[29:0];
      z      = ece_pkg::q_t'({12'b0, r[27:0]});
      b.sz   = r[28] ? ece_pkg::QOne - z : z;
      b.sneg = r[29];
      // exp2: clamp, split into integer and fraction
      if (ex < -40 * ece_pkg::QOne) ex = -40 * ece_pkg::QOne;
      if (ex > 20 * ece_pkg::QOne) ex = 20 * ece_pkg::QOne;
      xo   = ex + 64 * ece_pkg::QOne;
      b.en = $signed({1'b0, xo[34:28]}) - 8'sd64;
      b.ef = xo[27:0];
      b.ep = ece_pkg::ExpCoef[6];
      // sqrt: radicand scaled by 2^28
      if (sx <= 0) sx = '0;
      b.rv = {sx[28:0], 28'b0};
      b.rr = '0;
      // power: base, partner of the square, back-curve factor
      b.pb = tt;
      b.pm = tt;
      b.pl = '0;
      unique case (a.crv)
        ece_pkg::CrvQuadOut: b.pm = 2 * ece_pkg::QOne - tt;
        ece_pkg::CrvQuadInOut: begin
          if (!a.lo) b.pm = 4 * ece_pkg::QOne - 2 * tt;
        end
        ece_pkg::CrvCubicOut, ece_pkg::CrvQuartOut, ece_pkg::CrvQuintOut,
        ece_pkg::CrvBackOut, ece_pkg::CrvElasticOut: begin
          b.pb = uu;
          b.pm = uu;
        end
        ece_pkg::CrvCubicInOut: begin
          if (!a.lo) begin
            b.pb = 2 * ece_pkg::QOne - 2 * tt;
            b.pm = 2 * ece_pkg::QOne - 2 * tt;
          end
        end
        ece_pkg::CrvQuartInOut, ece_pkg::CrvQuintInOut: begin
          if (!a.lo) begin
            b.pb = uu;
            b.pm = uu;
          end
        end
        ece_pkg::CrvBackInOut: begin
          if (a.lo) begin
            b.pl = 7 * tt - 5 * ece_pkg::QHalf;
          end else begin
            b.pb = uu;
            b.pm = uu;
            b.pl = 7 * uu + 5 * ece_pkg::QHalf;
          end
        end
        ece_pkg::CrvElasticInOut: begin
          if (tt >= ece_pkg::K045) begin
            b.pb = uu;
            b.pm = uu;
          end
        end
        default: ;
      endcase
    end

    // sine unit: square, Horner steps, last product and sign
    if (k == StFirstMul) begin
      b.sz2 = ece_pkg::qmul(a.sz, a.sz);
      b.sp  = ece_pkg::SinCoef[4];
    end else if (k > StFirstMul && k < StSinLast) begin
      b.sp = ece_pkg::SinCoef[6 - k] - ece_pkg::qmul(a.sz2, a.sp);
    end else if (k == StSinLast) begin
      p = ece_pkg::qmul(a.sz, a.sp);
      if (p > ece_pkg::QOne) p = ece_pkg::QOne;
      if (p < 0) p = '0;
      b.sres = a.sneg ? -p : p;
    end

    // exp2 unit: Horner steps, then scale by the integer part
    if (k >= StFirstMul && k < StExpOne) begin
      b.ep = ece_pkg::ExpCoef[7 - k] + ece_pkg::qmul(ece_pkg::q_t'({12'b0, a.ef}), a.ep);
    end else if (k == StExpOne) begin
      b.ep = ece_pkg::QOne + ece_pkg::qmul(ece_pkg::q_t'({12'b0, a.ef}), a.ep);
    end else if (k == StExpShift) begin
      if (!a.en[7]) begin
        b.eres = a.ep <<< a.en[4:0];
      end else begin
        sh = 8'(-a.en);
        b.eres = (sh >= 8'd62) ? '0 : ece_pkg::rsr(a.ep, 32'(sh));
      end
    end

    // divide by 255 or 510 with rounding: fold base-256 digits
    if (k == StDivA) begin
      e1  = a.eres - ece_pkg::QOne;
      e1m = e1[39] ? '0 : e1[36:0];
      if (a.crv == ece_pkg::CrvExpoIn) b.dx = e1m + 37'd127;
      else b.dx = 37'(({1'b0, e1m} + 38'd255) >> 1);
      b.dq = '0;
      for (i = 0; i < 3; i++) begin
        b.dq = b.dq + 30'(b.dx >> 8);
        b.dx = 37'(b.dx >> 8) + 37'(b.dx[7:0]);
      end
    end else if (k == StDivB) begin
      for (i = 0; i < 2; i++) begin
        b.dq = b.dq + 30'(b.dx >> 8);
        b.dx = 37'(b.dx >> 8) + 37'(b.dx[7:0]);
      end
      if (b.dx == 37'd255) b.dq = b.dq + 30'd1;
    end

    // sqrt unit: two result bits per stage
    if (k >= StFirstMul && k <= StSqrtLast) begin
      for (i = 0; i < 2; i++) begin
        j = 2 * (k - StFirstMul) + i;
        if (j <= 28) begin
          bitv  = 58'd1 << (56 - 2 * j);
          trial = b.rr + bitv;
          if ({1'b0, b.rv} >= trial) begin
            b.rv = 57'({1'b0, b.rv} - trial);
            b.rr = (b.rr >> 1) + bitv;
          end else begin
            b.rr = b.rr >> 1;
          end
        end
      end
    end

    // power unit: square, cross product, fifth power
    if (k == StFirstMul) begin
      b.ps = ece_pkg::qmul(a.pb, a.pm);
      if (a.crv == ece_pkg::CrvBackIn) begin
        b.pl = ece_pkg::qmul(ece_pkg::KBackA, a.pb) - ece_pkg::KBackB;
      end else if (a.crv == ece_pkg::CrvBackOut) begin
        b.pl = ece_pkg::qmul(ece_pkg::KBackA, a.pb) + ece_pkg::KBackB;
      end
    end else if (k == StPowCross) begin
      unique case (a.crv)
        ece_pkg::CrvBackIn, ece_pkg::CrvBackOut, ece_pkg::CrvBackInOut: y = a.pl;
        ece_pkg::CrvQuartIn, ece_pkg::CrvQuartOut, ece_pkg::CrvQuartInOut,
        ece_pkg::CrvElasticIn, ece_pkg::CrvElasticOut,
        ece_pkg::CrvElasticInOut: y = a.ps;
        default: y = a.pb;
      endcase
      b.px = ece_pkg::qmul(a.ps, y);
    end else if (k == StPowFifth) begin
      if (a.crv == ece_pkg::CrvQuintIn || a.crv == ece_pkg::CrvQuintOut ||
          a.crv == ece_pkg::CrvQuintInOut) begin
        b.px = ece_pkg::qmul(a.px, a.ps);
      end
    end

    // mix: envelope times oscillation
    if (k == StMix) begin
      mx = a.px;
      my = a.sres;
      unique case (a.crv)
        ece_pkg::CrvElasticInOut: begin
          if (mid) mx = ece_pkg::K075;
        end
        ece_pkg::CrvBounceIn, ece_pkg::CrvBounceOut, ece_pkg::CrvBounceInOut: begin
          mx = a.eres;
          my = a.sres[39] ? -a.sres : a.sres;
        end
        default: ;
      endcase
      b.mres = ece_pkg::qmul(mx, my);
    end

    // assemble the curve value
    if (k == StAssemble) begin
      unique case (a.crv)
        ece_pkg::CrvLinear:    b.val = tt;
        ece_pkg::CrvSineIn:    b.val = a.sres;
        ece_pkg::CrvSineOut:   b.val = ece_pkg::QOne + a.sres;
        ece_pkg::CrvSineInOut: b.val = ece_pkg::rsr(ece_pkg::QOne + a.sres, 1);
        ece_pkg::CrvQuadIn:    b.val = a.ps;
        ece_pkg::CrvQuadOut:   b.val = a.ps;
        ece_pkg::CrvQuadInOut: b.val = a.lo ? 2 * a.ps : a.ps - ece_pkg::QOne;
        ece_pkg::CrvCubicIn:   b.val = a.px;
        ece_pkg::CrvCubicOut:  b.val = ece_pkg::QOne + a.px;
        ece_pkg::CrvCubicInOut:
          b.val = a.lo ? 4 * a.px : ece_pkg::QOne - ece_pkg::rsr(a.px, 1);
        ece_pkg::CrvQuartIn:    b.val = a.px;
        ece_pkg::CrvQuartOut:   b.val = ece_pkg::QOne - a.px;
        ece_pkg::CrvQuartInOut: b.val = a.lo ? 8 * a.px : ece_pkg::QOne - 8 * a.px;
        ece_pkg::CrvQuintIn:    b.val = a.px;
        ece_pkg::CrvQuintOut:   b.val = ece_pkg::QOne + a.px;
        ece_pkg::CrvQuintInOut: b.val = a.lo ? 16 * a.px : ece_pkg::QOne + 16 * a.px;
        ece_pkg::CrvExpoIn:     b.val = ece_pkg::q_t'({10'b0, a.dq});
        ece_pkg::CrvExpoOut:    b.val = ece_pkg::QOne - a.eres;
        ece_pkg::CrvExpoInOut:
          b.val = a.lo ? ece_pkg::q_t'({10'b0, a.dq})
                       : ece_pkg::QOne - ece_pkg::rsr(a.eres, 1);
        ece_pkg::CrvCircIn:  b.val = ece_pkg::QOne - ece_pkg::q_t'({11'b0, a.rr[28:0]});
        ece_pkg::CrvCircOut: b.val = ece_pkg::q_t'({11'b0, a.rr[28:0]});
        ece_pkg::CrvCircInOut:
          b.val = a.lo
            ? ece_pkg::rsr(ece_pkg::QOne - ece_pkg::q_t'({11'b0, a.rr[28:0]}), 1)
            : ece_pkg::rsr(ece_pkg::QOne + ece_pkg::q_t'({11'b0, a.rr[28:0]}), 1);
        ece_pkg::CrvBackIn:     b.val = a.px;
        ece_pkg::CrvBackOut:    b.val = ece_pkg::QOne + a.px;
        ece_pkg::CrvBackInOut:  b.val = a.lo ? 2 * a.px : ece_pkg::QOne + 2 * a.px;
        ece_pkg::CrvElasticIn:  b.val = a.mres;
        ece_pkg::CrvElasticOut: b.val = ece_pkg::QOne - a.mres;
        ece_pkg::CrvElasticInOut: begin
          if (tt < ece_pkg::K045) b.val = 8 * a.mres;
          else if (tt < ece_pkg::K055) b.val = ece_pkg::QHalf + a.mres;
          else b.val = ece_pkg::QOne - 8 * a.mres;
        end
        ece_pkg::CrvBounceIn:    b.val = a.mres;
        ece_pkg::CrvBounceOut:   b.val = ece_pkg::QOne - a.mres;
        ece_pkg::CrvBounceInOut: b.val = a.lo ? 8 * a.mres : ece_pkg::QOne - 8 * a.mres;
        default:                 b.val = '0;
      endcase
    end

    // round to the output format and saturate
    if (k == StRound) begin
      v = ece_pkg::rsr(a.val, ece_pkg::QB - ece_pkg::FracBits);
      if (v > ece_pkg::OutMax) v = ece_pkg::OutMax;
      if (v < ece_pkg::OutMin) v = ece_pkg::OutMin;
      b.res = v[17:0];
    end
    return b;
  endfunction

  // whole pipeline moves unless a result waits on the output
  assign adv           = !valid_q[NumStages-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = valid_q[NumStages-1];
  assign m_axis_tdata  = {6'b0, pipe_q[NumStages-1].res};

  // input capture: saturate progress to 1.0, move to the internal format
  always_comb begin
    raw = s_axis_tdata[16:0];
    if (raw > (17'd1 << ece_pkg::FracBits)) raw = 17'd1 << ece_pkg::FracBits;
    pipe_d[0]     = '0;
    pipe_d[0].crv = ece_pkg::curve_e'(curve_q);
    pipe_d[0].t   = ece_pkg::q_t'({23'b0, raw}) <<< (ece_pkg::QB - ece_pkg::FracBits);
    pipe_d[0].lo  = pipe_d[0].t < ece_pkg::QHalf;
    for (int k = 1; k < NumStages; k++) begin
      pipe_d[k] = step(k, pipe_q[k-1]);
    end
  end

  // control: curve register and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_q <= '0;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) curve_q <= cfg_wdata_i;
      if (adv) valid_q <= {valid_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumStages; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// self-checking bench for easing_curve_evaluator: directed table, then random
// progress for every curve setting, with a bit-exact eased value predictor
// depends on ece_pkg and easing_curve_evaluator
`timescale 1ns / 1ps

module tb;

  localparam longint OneQ   = 64'sd1 <<< 28;
  localparam longint HalfQ  = 64'sd1 <<< 27;
  localparam int     Shift  = 28 - ece_pkg::FracBits;
  localparam int     IdleLimit = 2000;
  localparam int     DrainCycles = 30;
  localparam int     UnusedCurve = 31;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  easing_curve_evaluator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [16:0] progress
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)    // [17:0] eased_value
  );

  always #6 clk_i = ~clk_i;

  logic [17:0] eased_expected_q [$];
  logic [4:0]  curve_now = '0;
  bit          quiet = 1'b0;
  int          errors = 0;
  int          sent = 0;
  int          received = 0;

  // ---------------- predictor ----------------
  function automatic longint unsigned mag_of(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = (mag_of(a) * mag_of(b) + (64'd1 << 27)) >> 28;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint fx_shr(longint x, int s);
    longint unsigned m;
    if (s == 0) return x;
    m = (mag_of(x) + (64'd1 << (s - 1))) >> s;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_div(longint x, longint unsigned d);
    longint unsigned m;
    m = (mag_of(x) + d / 2) / d;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint quarter_sine(longint z);
    longint z2, p;
    z2 = fx_mul(z, z);
    p = longint'(ece_pkg::SinCoef[3]) - fx_mul(z2, longint'(ece_pkg::SinCoef[4]));
    p = longint'(ece_pkg::SinCoef[2]) - fx_mul(z2, p);
    p = longint'(ece_pkg::SinCoef[1]) - fx_mul(z2, p);
    p = longint'(ece_pkg::SinCoef[0]) - fx_mul(z2, p);
    p = fx_mul(z, p);
    if (p > OneQ) p = OneQ;
    if (p < 0) p = 0;
    return p;
  endfunction

  // angle in quarter turns
  function automatic longint sine_turns(longint q);
    longint r, z, s;
    int quad;
    r = q & (4 * OneQ - 1);
    quad = int'(r >>> 28);
    z = r & (OneQ - 1);
    s = quad[0] ? quarter_sine(OneQ - z) : quarter_sine(z);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint pow2(longint x);
    longint xo, f, p;
    int n;
    if (x < -40 * OneQ) x = -40 * OneQ;
    if (x > 20 * OneQ) x = 20 * OneQ;
    xo = x + 64 * OneQ;
    n = int'(xo >>> 28) - 64;
    f = xo & (OneQ - 1);
    p = longint'(ece_pkg::ExpCoef[6]);
    for (int i = 5; i >= 0; i--) p = longint'(ece_pkg::ExpCoef[i]) + fx_mul(f, p);
    p = OneQ + fx_mul(f, p);
    if (n >= 0) return p <<< n;
    if (-n >= 62) return 0;
    return fx_shr(p, -n);
  endfunction

  function automatic longint root2(longint x);
    longint unsigned v, root, b;
    if (x <= 0) return 0;
    if (x > 4 * OneQ) x = 4 * OneQ;
    v = longint'(x) << 28;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic longint pow3(longint a);
    return fx_mul(fx_mul(a, a), a);
  endfunction

  function automatic longint pow4(longint a);
    longint s;
    s = fx_mul(a, a);
    return fx_mul(s, s);
  endfunction

  function automatic longint pow5(longint a);
    longint s;
    s = fx_mul(a, a);
    return fx_mul(fx_mul(a, s), s);
  endfunction

  function automatic longint abs_q(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic longint curve_value(logic [4:0] c, longint t);
    longint u;
    longint ka, kb;
    bit lo;
    u = t - OneQ;
    lo = t < HalfQ;
    ka = longint'(ece_pkg::KBackA);
    kb = longint'(ece_pkg::KBackB);
    case (ece_pkg::curve_e'(c))
      ece_pkg::CrvLinear:     return t;
      ece_pkg::CrvSineIn:     return sine_turns(t);
      ece_pkg::CrvSineOut:    return OneQ + sine_turns(u);
      ece_pkg::CrvSineInOut:  return fx_shr(OneQ + sine_turns(2 * t - OneQ), 1);
      ece_pkg::CrvQuadIn:     return fx_mul(t, t);
      ece_pkg::CrvQuadOut:    return fx_mul(t, 2 * OneQ - t);
      ece_pkg::CrvQuadInOut:
        return lo ? 2 * fx_mul(t, t) : fx_mul(t, 4 * OneQ - 2 * t) - OneQ;
      ece_pkg::CrvCubicIn:    return pow3(t);
      ece_pkg::CrvCubicOut:   return OneQ + pow3(u);
      ece_pkg::CrvCubicInOut:
        return lo ? 4 * pow3(t) : OneQ - fx_shr(pow3(2 * OneQ - 2 * t), 1);
      ece_pkg::CrvQuartIn:    return pow4(t);
      ece_pkg::CrvQuartOut:   return OneQ - pow4(u);
      ece_pkg::CrvQuartInOut: return lo ? 8 * pow4(t) : OneQ - 8 * pow4(u);
      ece_pkg::CrvQuintIn:    return pow5(t);
      ece_pkg::CrvQuintOut:   return OneQ + pow5(u);
      ece_pkg::CrvQuintInOut: return lo ? 16 * pow5(t) : OneQ + 16 * pow5(u);
      ece_pkg::CrvExpoIn:     return fx_div(pow2(8 * t) - OneQ, 255);
      ece_pkg::CrvExpoOut:    return OneQ - pow2(-8 * t);
      ece_pkg::CrvExpoInOut:
        return lo ? fx_div(pow2(16 * t) - OneQ, 510)
                  : OneQ - fx_shr(pow2(-16 * (t - HalfQ)), 1);
      ece_pkg::CrvCircIn:     return OneQ - root2(OneQ - t);
      ece_pkg::CrvCircOut:    return root2(t);
      ece_pkg::CrvCircInOut:
        return lo ? fx_shr(OneQ - root2(OneQ - 2 * t), 1)
                  : fx_shr(OneQ + root2(2 * t - OneQ), 1);
      ece_pkg::CrvBackIn:     return fx_mul(fx_mul(t, t), fx_mul(ka, t) - kb);
      ece_pkg::CrvBackOut:    return OneQ + fx_mul(fx_mul(u, u), fx_mul(ka, u) + kb);
      ece_pkg::CrvBackInOut:
        return lo ? 2 * fx_mul(fx_mul(t, t), 7 * t - 5 * HalfQ)
                  : OneQ + 2 * fx_mul(fx_mul(u, u), 7 * u + 5 * HalfQ);
      ece_pkg::CrvElasticIn:  return fx_mul(pow4(t), sine_turns(9 * t));
      ece_pkg::CrvElasticOut: return OneQ - fx_mul(pow4(u), sine_turns(9 * t + OneQ));
      ece_pkg::CrvElasticInOut: begin
        if (t < longint'(ece_pkg::K045)) return 8 * fx_mul(pow4(t), sine_turns(18 * t));
        if (t < longint'(ece_pkg::K055))
          return HalfQ + fx_mul(longint'(ece_pkg::K075), sine_turns(8 * t));
        return OneQ - 8 * fx_mul(pow4(u), sine_turns(18 * t));
      end
      ece_pkg::CrvBounceIn:   return fx_mul(pow2(6 * u), abs_q(sine_turns(7 * t)));
      ece_pkg::CrvBounceOut:
        return OneQ - fx_mul(pow2(-6 * t), abs_q(sine_turns(7 * t + OneQ)));
      ece_pkg::CrvBounceInOut:
        return lo ? 8 * fx_mul(pow2(8 * u), abs_q(sine_turns(14 * t)))
                  : OneQ - 8 * fx_mul(pow2(-8 * t), abs_q(sine_turns(14 * t)));
      default:                return 0;
    endcase
  endfunction

  function automatic logic [17:0] predict_eased(logic [4:0] c, logic [16:0] p);
    longint raw, v;
    raw = p;
    if (raw > (64'sd1 <<< ece_pkg::FracBits)) raw = 64'sd1 <<< ece_pkg::FracBits;
    v = fx_shr(curve_value(c, raw <<< Shift), Shift);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  // ---------------- stimulus ----------------
  task automatic send_progress(logic [16:0] p, bit known, logic [17:0] typed);
    if (!quiet && $urandom_range(99) < 35) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, p};
    do @(posedge clk_i); while (!s_axis_tready);
    eased_expected_q = {eased_expected_q, (known ? typed : predict_eased(curve_now, p))};
    sent++;
  endtask

  task automatic write_curve(logic [4:0] c);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (eased_expected_q.size() == 0);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    curve_now   = c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [16:0] random_progress();
    case ($urandom_range(9))
      0:       return 17'($urandom_range(131071));
      1:       return 17'($urandom_range(16));
      2:       return 17'(65536 - $urandom_range(16));
      3:       return 17'(32768 + $urandom_range(8) - 4);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  typedef struct {
    logic [4:0]  curve;
    logic [16:0] progress;
    bit          known;
    logic [17:0] eased;
  } row_t;

  row_t rows [] = '{
    '{5'(ece_pkg::CrvLinear), 17'd0, 1'b1, 18'd0},
    '{5'(ece_pkg::CrvLinear), 17'd65536, 1'b1, 18'd65536},
    '{5'(ece_pkg::CrvLinear), 17'd131071, 1'b1, 18'd65536},
    '{5'(ece_pkg::CrvLinear), 17'd65537, 1'b1, 18'd65536},
    '{5'(ece_pkg::CrvLinear), 17'd1, 1'b1, 18'd1},
    '{5'(ece_pkg::CrvQuadIn), 17'd0, 1'b1, 18'd0},
    '{5'(ece_pkg::CrvQuadIn), 17'd65536, 1'b1, 18'd65536},
    '{5'(ece_pkg::CrvQuadIn), 17'd131071, 1'b1, 18'd65536},
    '{5'(ece_pkg::CrvSineIn), 17'd32768, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvSineOut), 17'd65536, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvExpoIn), 17'd0, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvExpoInOut), 17'd32767, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvExpoInOut), 17'd32768, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvCircIn), 17'd65536, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvCircInOut), 17'd32768, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvBackIn), 17'd21845, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvBackInOut), 17'd65536, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvElasticInOut), 17'd29490, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvElasticInOut), 17'd36045, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvBounceOut), 17'd65535, 1'b0, 18'd0},
    '{5'(ece_pkg::CrvBounceInOut), 17'd32768, 1'b0, 18'd0},
    '{5'(UnusedCurve), 17'd40000, 1'b1, 18'd0},
    '{5'(UnusedCurve), 17'd131071, 1'b1, 18'd0}
  };

  // output side: random stalls unless in the quiet stretch
  always @(negedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 26);
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      received++;
      if (eased_expected_q.size() == 0) begin
        $error("unexpected result transfer, eased_value %0d", $signed(m_axis_tdata[17:0]));
        errors++;
      end else begin
        logic [17:0] want;
        want = eased_expected_q.pop_front();
        if (m_axis_tdata[17:0] !== want) begin
          $error("eased_value expected %0d actual %0d (curve %0d)", $signed(want),
                 $signed(m_axis_tdata[17:0]), curve_now);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [4:0] order [$];
    int per_curve;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, curve written for the first row and whenever it changes
    foreach (rows[i]) begin
      if (rows[i].curve != curve_now || i == 0) write_curve(rows[i].curve);
      send_progress(rows[i].progress, rows[i].known, rows[i].eased);
    end

    // random part: every curve, extremes first and last, one stall-free phase
    order = {order, 5'(ece_pkg::CrvBounceInOut)};
    order = {order, 5'(ece_pkg::CrvLinear)};
    for (int c = 1; c <= UnusedCurve; c++) order = {order, 5'(c)};
    order = {order, 5'(ece_pkg::CrvLinear)};
    per_curve = 1900 / order.size();
    foreach (order[k]) begin
      write_curve(order[k]);
      quiet = (k == 12);
      for (int n = 0; n < per_curve; n++) send_progress(random_progress(), 1'b0, '0);
    end
    quiet = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (eased_expected_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d progress items over all 32 curve settings, %0d results checked",
             sent, received);
    if (errors == 0 && eased_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ece_pkg.sv
hw/rtl/easing_curve_evaluator.sv
bench/tb.sv
